// File: rtl/core/tmaa_pkg.sv
`timescale 1ns / 1ps

package tmaa_pkg;

    // Operation codes carried by the kind field.
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ATLAS_W   = 2'd0;
    localparam logic [1:0] CFG_ATLAS_H   = 2'd1;
    localparam logic [1:0] CFG_SECTION_W = 2'd2;
    localparam logic [1:0] CFG_SECTION_H = 2'd3;

    localparam int CFG_W    = 13;
    localparam int ID_W     = 16;
    localparam int COORD_W  = 7;
    localparam int DIV_STEPS = ID_W;

    localparam logic [ID_W-1:0] EMPTY_ID = 16'hFFFF;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [ID_W-1:0]   dividend;
        logic [CFG_W-1:0]  divisor;
    } div_req_t;

    // Answer from the shared divider; quotient and remainder hold after done.
    typedef struct packed {
        logic              done;
        logic [ID_W-1:0]   quotient;
        logic [CFG_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// File: rtl/core/tmaa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module tmaa_div (
    input  logic                clk,
    input  logic                rst_n,
    input  tmaa_pkg::div_req_t  req,
    output tmaa_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(tmaa_pkg::DIV_STEPS);

    logic [tmaa_pkg::ID_W-1:0]  quo_reg, quo_next;
    logic [tmaa_pkg::CFG_W-1:0] rem_reg, rem_next;
    logic [tmaa_pkg::CFG_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [tmaa_pkg::CFG_W:0]   trial;
    logic [tmaa_pkg::CFG_W:0]   diff;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[tmaa_pkg::ID_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            quo_next   = req.dividend;
            rem_next   = '0;
            dvs_next   = req.divisor;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[tmaa_pkg::ID_W-2:0], fits};
            rem_next   = fits ? diff[tmaa_pkg::CFG_W-1:0] : trial[tmaa_pkg::CFG_W-1:0];
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(tmaa_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/core/tile_map_atlas_lookup.sv
`timescale 1ns / 1ps

// Tile map with texture atlas lookup. The block holds a grid of 16-bit tile
// ids (-1 marks an empty cell) in an on-chip memory of MAX_GRID_W x
// MAX_GRID_H entries and answers one transaction at a time: a write stores
// an id inside the grid, a query returns the id and its atlas rectangle, and
// a resize fills every newly exposed cell with a fill value. Every input
// transaction produces exactly one output transaction. A write, an unused
// kind or an out-of-grid query passes straight from acceptance to the
// result handover. A query inside the grid reads the cell, then runs the
// shared one-bit-per-cycle divider twice (tiles per row, then column and
// row of the id), followed by the multiply steps for x and y and a fit
// check. With a zero section width the first division is skipped, and a
// query that finds a negative id ends right after the read. A resize to
// W x H tiles sweeps the new grid, visiting one cell per cycle through the
// single memory write port. No clearing pass is needed after reset: cells
// outside the current grid are always refilled by a resize before they
// can be read, and the one cell of the reset grid carries its own written
// flag. The input stalls while a transaction is in progress; the output
// register lets a finished result wait for the consumer while the next
// input transaction is taken.
// Configuration registers may be written only while the block is idle.
module tile_map_atlas_lookup #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_write_en,
    input  logic [1:0]                         cfg_index,
    input  logic [tmaa_pkg::CFG_W-1:0]         cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic signed [tmaa_pkg::COORD_W-1:0] tile_x,
    input  logic signed [tmaa_pkg::COORD_W-1:0] tile_y,
    input  logic signed [tmaa_pkg::ID_W-1:0]   tile_value_in,
    input  logic [tmaa_pkg::COORD_W-1:0]       new_width,
    input  logic [tmaa_pkg::COORD_W-1:0]       new_height,
    input  logic signed [tmaa_pkg::ID_W-1:0]   fill_value,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               position_valid,
    output logic signed [tmaa_pkg::ID_W-1:0]   tile_value_out,
    output logic [tmaa_pkg::CFG_W-1:0]         section_x,
    output logic [tmaa_pkg::CFG_W-1:0]         section_y,
    output logic [tmaa_pkg::CFG_W-1:0]         section_w,
    output logic [tmaa_pkg::CFG_W-1:0]         section_h
);

    localparam int DEPTH  = MAX_GRID_W * MAX_GRID_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = tmaa_pkg::COORD_W;
    localparam int IW     = tmaa_pkg::ID_W;
    localparam int RW     = tmaa_pkg::CFG_W;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_READ    = 9'b000000010,
        ST_DIV_TPR = 9'b000000100,
        ST_DIV_ID  = 9'b000001000,
        ST_MUL_X   = 9'b000010000,
        ST_MUL_Y   = 9'b000100000,
        ST_FIT     = 9'b001000000,
        ST_SWEEP   = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [RW-1:0] atlas_w_reg, atlas_h_reg, sect_w_reg, sect_h_reg;

    // Grid geometry and the written flag of cell (0,0).
    logic [CW-1:0] grid_w_reg, grid_w_next;
    logic [CW-1:0] grid_h_reg, grid_h_next;
    logic          cell0_written_reg, cell0_written_next;

    // Working registers of one transaction.
    logic              rd_zero_reg, rd_zero_next;
    logic [IW-1:0]     id_reg, id_next;
    logic [RW-1:0]     col_reg, col_next;
    logic [IW-1:0]     row_reg, row_next;
    logic [2*RW-1:0]   px_reg, px_next;
    logic [IW+RW-1:0]  py_reg, py_next;
    logic [CW-1:0]     nw_reg, nw_next;
    logic [CW-1:0]     nh_reg, nh_next;
    logic [IW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     cx_reg, cx_next;
    logic [CW-1:0]     cy_reg, cy_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;

    // Result being built, then the output register.
    logic          res_pos_reg, res_pos_next;
    logic [IW-1:0] res_value_reg, res_value_next;
    logic [RW-1:0] res_sx_reg, res_sx_next;
    logic [RW-1:0] res_sy_reg, res_sy_next;
    logic [RW-1:0] res_sw_reg, res_sw_next;
    logic [RW-1:0] res_sh_reg, res_sh_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_pos_reg, out_pos_next;
    logic [IW-1:0] out_value_reg, out_value_next;
    logic [RW-1:0] out_sx_reg, out_sx_next;
    logic [RW-1:0] out_sy_reg, out_sy_next;
    logic [RW-1:0] out_sw_reg, out_sw_next;
    logic [RW-1:0] out_sh_reg, out_sh_next;

    // Tile memory: one write port, one registered read port.
    logic [IW-1:0]     tile_mem [DEPTH];
    logic [IW-1:0]     rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [IW-1:0]     mem_wdata;

    tmaa_pkg::div_req_t div_req;
    tmaa_pkg::div_rsp_t div_rsp;

    // Decoding of the incoming transaction.
    logic [CW-1:0]     tx_u, ty_u;
    logic              in_grid;
    logic [ADDR_W-1:0] pos_addr;
    logic [CW-1:0]     nw_sat, nh_sat;
    logic              accept;

    // Helpers for the sweep, the query and the fit check.
    logic          outside_old;
    logic          row_last;
    logic          col_last;
    logic [IW-1:0] read_id;
    logic [RW-1:0] tpr;
    logic          fit_x, fit_y;

    tmaa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    assign tx_u    = tile_x;
    assign ty_u    = tile_y;
    assign in_grid = !tile_x[CW-1] && !tile_y[CW-1]
                     && (tx_u < grid_w_reg) && (ty_u < grid_h_reg);
    assign pos_addr = ADDR_W'(32'(ty_u) * 32'(MAX_GRID_W) + 32'(tx_u));
    assign rd_addr  = pos_addr;

    assign nw_sat = (32'(new_width) > 32'(MAX_GRID_W)) ? CW'(MAX_GRID_W) : new_width;
    assign nh_sat = (32'(new_height) > 32'(MAX_GRID_H)) ? CW'(MAX_GRID_H) : new_height;

    assign outside_old = !((cx_reg < grid_w_reg) && (cy_reg < grid_h_reg));
    assign col_last    = (cx_reg == nw_reg - CW'(1));
    assign row_last    = (cy_reg == nh_reg - CW'(1));

    // Cell (0,0) reads as empty until something has been written to it.
    assign read_id = (rd_zero_reg && !cell0_written_reg) ? tmaa_pkg::EMPTY_ID : rd_data_reg;

    // Tiles per row never drops below one.
    assign tpr = (div_rsp.quotient == '0) ? RW'(1) : div_rsp.quotient[RW-1:0];

    assign fit_x = ({1'b0, px_reg} + (2*RW+1)'(sect_w_reg)) <= (2*RW+1)'(atlas_w_reg);
    assign fit_y = ({1'b0, py_reg} + (IW+RW+1)'(sect_h_reg)) <= (IW+RW+1)'(atlas_h_reg);

    // Memory write port: direct writes at acceptance, fill writes during a sweep.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_addr;
        mem_wdata = tile_value_in;
        if (accept && (kind == tmaa_pkg::KIND_WRITE) && in_grid)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == ST_SWEEP) && outside_old)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_base_reg + ADDR_W'(cx_reg);
            mem_wdata = fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tile_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tile_mem[rd_addr];
    end

    // Divider requests: tiles per row first when the section width is nonzero, then the id split.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = id_reg;
        div_req.divisor  = sect_w_reg;
        if ((state_reg == ST_READ) && !read_id[IW-1])
        begin
            div_req.start = 1'b1;
            if (sect_w_reg != '0)
            begin
                div_req.dividend = IW'(atlas_w_reg);
            end
            else
            begin
                div_req.dividend = read_id;
                div_req.divisor  = RW'(1);
            end
        end
        else if ((state_reg == ST_DIV_TPR) && div_rsp.done)
        begin
            div_req.start   = 1'b1;
            div_req.divisor = tpr;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        grid_w_next        = grid_w_reg;
        grid_h_next        = grid_h_reg;
        cell0_written_next = cell0_written_reg;
        rd_zero_next       = rd_zero_reg;
        id_next            = id_reg;
        col_next           = col_reg;
        row_next           = row_reg;
        px_next            = px_reg;
        py_next            = py_reg;
        nw_next            = nw_reg;
        nh_next            = nh_reg;
        fill_next          = fill_reg;
        cx_next            = cx_reg;
        cy_next            = cy_reg;
        row_base_next      = row_base_reg;
        res_pos_next       = res_pos_reg;
        res_value_next     = res_value_reg;
        res_sx_next        = res_sx_reg;
        res_sy_next        = res_sy_reg;
        res_sw_next        = res_sw_reg;
        res_sh_next        = res_sh_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_pos_next       = out_pos_reg;
        out_value_next     = out_value_reg;
        out_sx_next        = out_sx_reg;
        out_sy_next        = out_sy_reg;
        out_sw_next        = out_sw_reg;
        out_sh_next        = out_sh_reg;

        if (mem_we && (mem_waddr == '0))
        begin
            cell0_written_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_pos_next   = 1'b0;
                    res_value_next = tmaa_pkg::EMPTY_ID;
                    res_sx_next    = '0;
                    res_sy_next    = '0;
                    res_sw_next    = '0;
                    res_sh_next    = '0;
                    rd_zero_next   = (pos_addr == '0);
                    nw_next        = nw_sat;
                    nh_next        = nh_sat;
                    fill_next      = fill_value;
                    cx_next        = '0;
                    cy_next        = '0;
                    row_base_next  = '0;
                    state_next     = ST_FINISH;
                    case (kind)
                        tmaa_pkg::KIND_WRITE:
                        begin
                            res_pos_next = in_grid;
                        end
                        tmaa_pkg::KIND_QUERY:
                        begin
                            res_pos_next = in_grid;
                            if (in_grid)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        tmaa_pkg::KIND_RESIZE:
                        begin
                            if ((nw_sat == '0) || (nh_sat == '0))
                            begin
                                grid_w_next = nw_sat;
                                grid_h_next = nh_sat;
                            end
                            else
                            begin
                                state_next = ST_SWEEP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                id_next        = read_id;
                res_value_next = read_id;
                if (read_id[IW-1])
                begin
                    state_next = ST_FINISH;
                end
                else if (sect_w_reg != '0)
                begin
                    state_next = ST_DIV_TPR;
                end
                else
                begin
                    state_next = ST_DIV_ID;
                end
            end

            ST_DIV_TPR:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_ID;
                end
            end

            ST_DIV_ID:
            begin
                if (div_rsp.done)
                begin
                    col_next   = div_rsp.remainder;
                    row_next   = div_rsp.quotient;
                    state_next = ST_MUL_X;
                end
            end

            ST_MUL_X:
            begin
                px_next    = (2*RW)'(col_reg) * (2*RW)'(sect_w_reg);
                state_next = ST_MUL_Y;
            end

            ST_MUL_Y:
            begin
                py_next    = (IW+RW)'(row_reg) * (IW+RW)'(sect_h_reg);
                state_next = ST_FIT;
            end

            ST_FIT:
            begin
                if (fit_x && fit_y)
                begin
                    res_sx_next = px_reg[RW-1:0];
                    res_sy_next = py_reg[RW-1:0];
                    res_sw_next = sect_w_reg;
                    res_sh_next = sect_h_reg;
                end
                state_next = ST_FINISH;
            end

            ST_SWEEP:
            begin
                if (col_last)
                begin
                    cx_next       = '0;
                    cy_next       = cy_reg + CW'(1);
                    row_base_next = row_base_reg + ADDR_W'(MAX_GRID_W);
                    if (row_last)
                    begin
                        grid_w_next = nw_reg;
                        grid_h_next = nh_reg;
                        state_next  = ST_FINISH;
                    end
                end
                else
                begin
                    cx_next = cx_reg + CW'(1);
                end
            end

            ST_FINISH:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = res_pos_reg;
                    out_value_next = res_value_reg;
                    out_sx_next    = res_sx_reg;
                    out_sy_next    = res_sy_reg;
                    out_sw_next    = res_sw_reg;
                    out_sh_next    = res_sh_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= '0;
            atlas_h_reg <= '0;
            sect_w_reg  <= RW'(32);
            sect_h_reg  <= RW'(32);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tmaa_pkg::CFG_ATLAS_W:   atlas_w_reg <= cfg_data;
                tmaa_pkg::CFG_ATLAS_H:   atlas_h_reg <= cfg_data;
                tmaa_pkg::CFG_SECTION_W: sect_w_reg  <= cfg_data;
                tmaa_pkg::CFG_SECTION_H: sect_h_reg  <= cfg_data;
                default:                 atlas_w_reg <= atlas_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            grid_w_reg        <= CW'(1);
            grid_h_reg        <= CW'(1);
            cell0_written_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            grid_w_reg        <= grid_w_next;
            grid_h_reg        <= grid_h_next;
            cell0_written_reg <= cell0_written_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge clk)
    begin
        rd_zero_reg   <= rd_zero_next;
        id_reg        <= id_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        nw_reg        <= nw_next;
        nh_reg        <= nh_next;
        fill_reg      <= fill_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        row_base_reg  <= row_base_next;
        res_pos_reg   <= res_pos_next;
        res_value_reg <= res_value_next;
        res_sx_reg    <= res_sx_next;
        res_sy_reg    <= res_sy_next;
        res_sw_reg    <= res_sw_next;
        res_sh_reg    <= res_sh_next;
        out_pos_reg   <= out_pos_next;
        out_value_reg <= out_value_next;
        out_sx_reg    <= out_sx_next;
        out_sy_reg    <= out_sy_next;
        out_sw_reg    <= out_sw_next;
        out_sh_reg    <= out_sh_next;
    end

    assign out_valid      = out_valid_reg;
    assign position_valid = out_pos_reg;
    assign tile_value_out = out_value_reg;
    assign section_x      = out_sx_reg;
    assign section_y      = out_sy_reg;
    assign section_w      = out_sw_reg;
    assign section_h      = out_sh_reg;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the tile map with atlas lookup. Transactions are
// driven on the falling edge and every handshake is observed on the rising
// edge. Each accepted input transaction is run through a cycle-free copy of
// the tile map inside this bench, and its answer, or the hand-written one
// where the script gives it, is queued. Each accepted output transaction is compared with the oldest queued answer.
module tb;

    // The kind code that the block must treat as a no-op.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int GRID_MAX = 64;

    // One input transaction, in the order of the input ports.
    typedef struct packed {
        logic [1:0]                kind;
        logic [6:0]                x;
        logic [6:0]                y;
        logic [tmaa_pkg::ID_W-1:0] value;
        logic [6:0]                nw;
        logic [6:0]                nh;
        logic [tmaa_pkg::ID_W-1:0] fill;
    } tile_op_t;

    // One output transaction: the grid hit flag, the id and its atlas rectangle.
    typedef struct packed {
        logic                       pos_ok;
        logic [tmaa_pkg::ID_W-1:0]  id;
        logic [tmaa_pkg::CFG_W-1:0] sx;
        logic [tmaa_pkg::CFG_W-1:0] sy;
        logic [tmaa_pkg::CFG_W-1:0] sw;
        logic [tmaa_pkg::CFG_W-1:0] sh;
    } lookup_t;

    // A row of the directed script: either a full register setting or one
    // transaction, optionally with its answer written out by hand.
    typedef struct {
        bit                         is_cfg;
        logic [tmaa_pkg::CFG_W-1:0] aw;
        logic [tmaa_pkg::CFG_W-1:0] ah;
        logic [tmaa_pkg::CFG_W-1:0] sw;
        logic [tmaa_pkg::CFG_W-1:0] sh;
        tile_op_t                   op;
        bit                         fixed;
        lookup_t                    answer;
    } script_row_t;

    // Answers that can be read off directly: a miss (outside the grid, a
    // resize or the spare kind) and a hit on a write or an empty cell.
    localparam lookup_t MISS      = '{pos_ok: 1'b0, id: tmaa_pkg::EMPTY_ID, default: '0};
    localparam lookup_t HIT_EMPTY = '{pos_ok: 1'b1, id: tmaa_pkg::EMPTY_ID, default: '0};

    logic clk;
    logic rst_n;

    logic                       cfg_write_en;
    logic [1:0]                 cfg_index;
    logic [tmaa_pkg::CFG_W-1:0] cfg_data;

    logic                                in_valid;
    logic                                in_stall;
    logic [1:0]                          kind;
    logic signed [tmaa_pkg::COORD_W-1:0] tile_x;
    logic signed [tmaa_pkg::COORD_W-1:0] tile_y;
    logic signed [tmaa_pkg::ID_W-1:0]    tile_value_in;
    logic [tmaa_pkg::COORD_W-1:0]        new_width;
    logic [tmaa_pkg::COORD_W-1:0]        new_height;
    logic signed [tmaa_pkg::ID_W-1:0]    fill_value;

    logic                             out_valid;
    logic                             out_stall;
    logic                             position_valid;
    logic signed [tmaa_pkg::ID_W-1:0] tile_value_out;
    logic [tmaa_pkg::CFG_W-1:0]       section_x;
    logic [tmaa_pkg::CFG_W-1:0]       section_y;
    logic [tmaa_pkg::CFG_W-1:0]       section_w;
    logic [tmaa_pkg::CFG_W-1:0]       section_h;

    // Shadow of the block's state, updated at the edge where a transaction is
    // accepted, and just after the edge that takes a register write.
    logic [tmaa_pkg::ID_W-1:0]  tile_mem [0:GRID_MAX-1][0:GRID_MAX-1];
    int                         map_w;
    int                         map_h;
    logic [tmaa_pkg::CFG_W-1:0] atlas_w_cfg;
    logic [tmaa_pkg::CFG_W-1:0] atlas_h_cfg;
    logic [tmaa_pkg::CFG_W-1:0] sect_w_cfg;
    logic [tmaa_pkg::CFG_W-1:0] sect_h_cfg;

    lookup_t     awaited_lookups [$];
    script_row_t script_q [$];
    int          bad_results;

    // A hand-written answer for the transaction currently on the input.
    bit      cur_fixed;
    lookup_t cur_answer;

    // While set, neither side idles, so back-to-back traffic is exercised.
    bit steady_phase;

    tile_map_atlas_lookup #(
        .MAX_GRID_W (GRID_MAX),
        .MAX_GRID_H (GRID_MAX)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .tile_x         (tile_x),
        .tile_y         (tile_y),
        .tile_value_in  (tile_value_in),
        .new_width      (new_width),
        .new_height     (new_height),
        .fill_value     (fill_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position_valid (position_valid),
        .tile_value_out (tile_value_out),
        .section_x      (section_x),
        .section_y      (section_y),
        .section_w      (section_w),
        .section_h      (section_h)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Applies one transaction to the shadow tile map and returns the answer
    // that the block must give for it.
    function automatic lookup_t tile_map_apply(tile_op_t op);
        lookup_t                   r;
        int                        xi;
        int                        yi;
        int                        nw;
        int                        nh;
        bit                        on_grid;
        logic [tmaa_pkg::ID_W-1:0] id;
        longint unsigned           per_row;
        longint unsigned           col;
        longint unsigned           row;
        longint unsigned           px;
        longint unsigned           py;
        r = MISS;
        xi = $signed(op.x);
        yi = $signed(op.y);
        on_grid = xi >= 0 && yi >= 0 && xi < map_w && yi < map_h;
        case (op.kind)
            tmaa_pkg::KIND_WRITE:
            begin
                if (on_grid)
                begin
                    tile_mem[yi][xi] = op.value;
                    r.pos_ok = 1'b1;
                end
            end
            tmaa_pkg::KIND_QUERY:
            begin
                if (on_grid)
                begin
                    id = tile_mem[yi][xi];
                    r.pos_ok = 1'b1;
                    r.id = id;
                    // A negative id has no section at all.
                    if (!id[tmaa_pkg::ID_W-1])
                    begin
                        per_row = (sect_w_cfg != 0) ? atlas_w_cfg / sect_w_cfg : 0;
                        if (per_row == 0)
                            per_row = 1;
                        col = id % per_row;
                        row = id / per_row;
                        px = col * sect_w_cfg;
                        py = row * sect_h_cfg;
                        // The fit test is done at full width, so a huge row
                        // never wraps back into the atlas.
                        if (px + sect_w_cfg <= atlas_w_cfg && py + sect_h_cfg <= atlas_h_cfg)
                        begin
                            r.sx = px[tmaa_pkg::CFG_W-1:0];
                            r.sy = py[tmaa_pkg::CFG_W-1:0];
                            r.sw = sect_w_cfg;
                            r.sh = sect_h_cfg;
                        end
                    end
                end
            end
            tmaa_pkg::KIND_RESIZE:
            begin
                nw = (op.nw > GRID_MAX) ? GRID_MAX : op.nw;
                nh = (op.nh > GRID_MAX) ? GRID_MAX : op.nh;
                // Cells shared by the old and the new grid keep their ids.
                for (int cy = 0; cy < nh; cy++)
                    for (int cx = 0; cx < nw; cx++)
                        if (!(cx < map_w && cy < map_h))
                            tile_mem[cy][cx] = op.fill;
                map_w = nw;
                map_h = nh;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic tile_op_t make_op(logic [1:0] k, int x, int y, int value,
                                         int nw, int nh, int fill);
        tile_op_t op;
        op.kind = k;
        op.x = 7'(x);
        op.y = 7'(y);
        op.value = 16'(value);
        op.nw = 7'(nw);
        op.nh = 7'(nh);
        op.fill = 16'(fill);
        return op;
    endfunction

    function automatic void add_op(bit fixed, lookup_t answer, tile_op_t op);
        script_row_t row;
        row = '{is_cfg: 1'b0, fixed: fixed, answer: answer, op: op, default: '0};
        script_q.push_back(row);
    endfunction

    function automatic void add_cfg(int aw, int ah, int sw, int sh);
        script_row_t row;
        row = '{is_cfg: 1'b1, default: '0};
        row.aw = 13'(aw);
        row.ah = 13'(ah);
        row.sw = 13'(sw);
        row.sh = 13'(sh);
        script_q.push_back(row);
    endfunction

    // Idle length in cycles: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // A random transaction, shaped by the current grid: most positions fall
    // inside it, most ids are small enough to land in the atlas, and most
    // resizes stay small because the block sweeps every new cell.
    function automatic tile_op_t random_op();
        tile_op_t op;
        int       r;
        int       sz;
        op = make_op(tmaa_pkg::KIND_WRITE, 0, 0, 0, 0, 0, 0);
        op.value = 16'($urandom);
        op.fill = 16'($urandom);
        op.nw = 7'($urandom);
        op.nh = 7'($urandom);
        r = $urandom_range(0, 99);
        if (r < 38)
            op.kind = tmaa_pkg::KIND_WRITE;
        else if (r < 82)
            op.kind = tmaa_pkg::KIND_QUERY;
        else if (r < 94)
            op.kind = tmaa_pkg::KIND_RESIZE;
        else
            op.kind = KIND_SPARE;

        r = $urandom_range(0, 99);
        if (map_w > 0 && map_h > 0 && r < 80)
        begin
            op.x = 7'($urandom_range(0, map_w - 1));
            op.y = 7'($urandom_range(0, map_h - 1));
        end
        else if (r < 90)
        begin
            // Just off an edge of the grid.
            op.x = ($urandom_range(0, 1) != 0) ? 7'(map_w) : 7'(-1);
            op.y = 7'($urandom_range(0, map_h));
        end
        else
        begin
            op.x = 7'($urandom);
            op.y = 7'($urandom);
        end

        r = $urandom_range(0, 99);
        if (r < 60)
            op.value = 16'($urandom_range(0, 31));
        else if (r < 80)
            op.value = 16'($urandom_range(0, 32767));
        else if (r < 90)
            op.value = tmaa_pkg::EMPTY_ID;

        if (op.kind == tmaa_pkg::KIND_RESIZE)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                sz = 0;
            else if (r < 92)
                sz = $urandom_range(1, 10);
            else if (r < 96)
                sz = $urandom_range(11, 20);
            else
                sz = -1;
            if (sz >= 0)
            begin
                op.nw = 7'(sz);
                op.nh = 7'((sz == 0) ? $urandom_range(0, 10) : $urandom_range(1, 10));
            end
            else
            begin
                op.nw = 7'($urandom_range(48, 127));
                op.nh = 7'($urandom_range(48, 127));
            end
            if ($urandom_range(0, 9) == 0)
                op.fill = tmaa_pkg::EMPTY_ID;
            else if ($urandom_range(0, 1) != 0)
                op.fill = 16'($urandom_range(0, 31));
        end
        return op;
    endfunction

    function automatic void check_lookup(lookup_t got);
        lookup_t want;
        if (awaited_lookups.size() == 0)
        begin
            bad_results++;
            if (bad_results <= 10)
                $display("%0t: result with nothing expected: valid=%0b id=%h rect=%0d,%0d,%0d,%0d",
                         $realtime, got.pos_ok, got.id, got.sx, got.sy, got.sw, got.sh);
            return;
        end
        want = awaited_lookups.pop_front();
        if (got !== want)
        begin
            bad_results++;
            if (bad_results <= 10)
            begin
                $display("%0t: result mismatch", $realtime);
                $display("    position_valid exp %0b got %0b", want.pos_ok, got.pos_ok);
                $display("    tile_value_out exp %h got %h", want.id, got.id);
                $display("    section_x exp %0d got %0d", want.sx, got.sx);
                $display("    section_y exp %0d got %0d", want.sy, got.sy);
                $display("    section_w exp %0d got %0d", want.sw, got.sw);
                $display("    section_h exp %0d got %0d", want.sh, got.sh);
            end
        end
    endfunction

    // Both handshakes are observed here on the rising edge. The result side
    // is handled first, so a result and a new input on the same edge keep
    // their order in the queue.
    always @(posedge clk)
    begin
        tile_op_t op;
        lookup_t  answer;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_lookup({position_valid, tile_value_out, section_x, section_y,
                              section_w, section_h});
            if (in_valid && !in_stall)
            begin
                op = {kind, tile_x, tile_y, tile_value_in, new_width, new_height, fill_value};
                answer = tile_map_apply(op);
                if (cur_fixed)
                    answer = cur_answer;
                awaited_lookups.push_back(answer);
            end
        end
    end

    // Result side back-pressure: random stretches of stall and release,
    // switched off while a steady phase runs.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady_phase)
                out_stall = 1'b0;
            else
            begin
                out_stall = ($urandom_range(0, 99) < 30);
                repeat (idle_length()) @(negedge clk);
            end
        end
    end

    // Drives one transaction; entered and left just after a falling edge.
    task automatic issue_op(tile_op_t op, int gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind = op.kind;
        tile_x = op.x;
        tile_y = op.y;
        tile_value_in = op.value;
        new_width = op.nw;
        new_height = op.nh;
        fill_value = op.fill;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived, with the input idle.
    task automatic drain();
        in_valid = 1'b0;
        while (awaited_lookups.size() != 0)
            @(negedge clk);
    endtask

    // Writes all four atlas registers on consecutive edges; the block must
    // be idle. The shadow follows each write just after the edge that takes it.
    task automatic program_atlas(logic [tmaa_pkg::CFG_W-1:0] aw, logic [tmaa_pkg::CFG_W-1:0] ah,
                                 logic [tmaa_pkg::CFG_W-1:0] sw, logic [tmaa_pkg::CFG_W-1:0] sh);
        cfg_write_en = 1'b1;
        cfg_index = tmaa_pkg::CFG_ATLAS_W;
        cfg_data = aw;
        @(negedge clk);
        atlas_w_cfg = aw;
        cfg_index = tmaa_pkg::CFG_ATLAS_H;
        cfg_data = ah;
        @(negedge clk);
        atlas_h_cfg = ah;
        cfg_index = tmaa_pkg::CFG_SECTION_W;
        cfg_data = sw;
        @(negedge clk);
        sect_w_cfg = sw;
        cfg_index = tmaa_pkg::CFG_SECTION_H;
        cfg_data = sh;
        @(negedge clk);
        sect_h_cfg = sh;
        cfg_write_en = 1'b0;
    endtask

    // A random register setting, leaning toward the extremes.
    function automatic logic [tmaa_pkg::CFG_W-1:0] random_atlas_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 35)
            return 13'd4096;
        else if (r < 45)
            return 13'($urandom_range(4097, 8191));
        else
            return 13'($urandom_range(0, 4096));
    endfunction

    function automatic logic [tmaa_pkg::CFG_W-1:0] random_section_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 20)
            return 13'd4096;
        else if (r < 80)
            return 13'($urandom_range(1, 64));
        else
            return 13'($urandom_range(1, 4096));
    endfunction

    // Ends a hung run.
    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = tmaa_pkg::CFG_ATLAS_W;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = tmaa_pkg::KIND_WRITE;
        tile_x = '0;
        tile_y = '0;
        tile_value_in = '0;
        new_width = '0;
        new_height = '0;
        fill_value = '0;
        cur_fixed = 1'b0;
        cur_answer = MISS;
        steady_phase = 1'b0;
        bad_results = 0;

        // Shadow state after reset: an empty 1 x 1 grid and no atlas.
        for (int yy = 0; yy < GRID_MAX; yy++)
            for (int xx = 0; xx < GRID_MAX; xx++)
                tile_mem[yy][xx] = tmaa_pkg::EMPTY_ID;
        map_w = 1;
        map_h = 1;
        atlas_w_cfg = '0;
        atlas_h_cfg = '0;
        sect_w_cfg = 13'd32;
        sect_h_cfg = 13'd32;

        // Directed part. The first rows run with the reset registers, where
        // the atlas is empty and every rectangle comes back zero.
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_QUERY, -1, 0, 0, 0, 0, 0));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_QUERY, 1, 0, 0, 0, 0, 0));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_QUERY, 0, -64, 0, 0, 0, 0));
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_WRITE, 0, 0, 5, 0, 0, 0));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_WRITE, 63, 0, 9, 0, 0, 0));
        // The spare kind must leave the stored id alone.
        add_op(1, MISS, make_op(KIND_SPARE, 0, 0, 'h1234, 127, 127, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0));
        // Oversized resize saturates to the full grid and keeps cell (0,0).
        add_op(1, MISS, make_op(tmaa_pkg::KIND_RESIZE, 0, 0, 0, 127, 100, 32767));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 63, 63, 0, 0, 0, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0));
        // An empty grid turns every position away.
        add_op(1, MISS, make_op(tmaa_pkg::KIND_RESIZE, 0, 0, 0, 0, 0, -1));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_WRITE, 0, 0, 1, 0, 0, 0));
        add_op(1, MISS, make_op(tmaa_pkg::KIND_RESIZE, 0, 0, 0, 3, 2, 3));
        // Four sections per row and four rows.
        add_cfg(128, 64, 32, 16);
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 2, 1, 0, 0, 0, 0));
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_WRITE, 1, 1, 15, 0, 0, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 1, 1, 0, 0, 0, 0));
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_WRITE, 0, 0, 16, 0, 0, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0));
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_WRITE, 2, 0, -32768, 0, 0, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 2, 0, 0, 0, 0, 0));
        // Zero section width counts as one section per row, so the id picks
        // the row alone; a large id then falls far below the atlas.
        add_cfg(4096, 4096, 0, 1);
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 1, 1, 0, 0, 0, 0));
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_WRITE, 0, 1, 32767, 0, 0, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 0, 1, 0, 0, 0, 0));
        add_op(1, HIT_EMPTY, make_op(tmaa_pkg::KIND_WRITE, 2, 1, -1, 0, 0, 0));
        add_op(0, MISS, make_op(tmaa_pkg::KIND_QUERY, 2, 1, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script_q[i])
        begin
            if (script_q[i].is_cfg)
            begin
                drain();
                program_atlas(script_q[i].aw, script_q[i].ah, script_q[i].sw, script_q[i].sh);
            end
            else
            begin
                cur_fixed = script_q[i].fixed;
                cur_answer = script_q[i].answer;
                issue_op(script_q[i].op, idle_length());
            end
        end
        cur_fixed = 1'b0;

        // Random part: eight register settings of about a hundred
        // transactions each. The first two are the atlas extremes, and every
        // third phase runs without idling on either side.
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: program_atlas(13'd4096, 13'd4096, 13'd1, 13'd1);
                1: program_atlas(13'd4096, 13'd4096, 13'd4096, 13'd4096);
                default: program_atlas(random_atlas_size(), random_atlas_size(),
                                       random_section_size(), random_section_size());
            endcase
            steady_phase = (phase % 3 == 2);
            for (int n = 0; n < 100; n++)
                issue_op(random_op(), steady_phase ? 0 : idle_length());
        end

        steady_phase = 1'b0;
        drain();
        // Keep the clock running to catch any stray result.
        repeat (60) @(posedge clk);

        if (bad_results == 0 && awaited_lookups.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
